// ----- sv/bia_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// bia_pkg
// Shared types, sizes and helpers for the bitmap ID allocator.
// -----------------------------------------------------------------------------
package bia_pkg;

    localparam int MAX_IDS   = 256;
    localparam int MAP_BYTES = (MAX_IDS + 7) / 8;
    localparam int IDX_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAX_IDS + 1);
    localparam int ID_W      = IDX_W + 3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [ID_W-1:0]  t_full_id;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] free_id;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] given_id;
        logic [8:0] live_count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, rewind scan pointer
        logic step;    // advance scan pointer
        logic commit;  // update map and count, load result register
        logic alloc;   // current request is an allocate
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic open_found;  // current byte has a clear, valid bit
        logic last_byte;   // scan pointer is at the final byte
    } t_sts;

    // Bits of byte b that map to IDs below MAX_IDS.
    function automatic logic [7:0] valid_mask(input t_idx b);
        int left;
        left = MAX_IDS - int'(b) * 8;
        if (left >= 8) begin
            valid_mask = 8'hff;
        end else begin
            valid_mask = 8'((32'd1 << left) - 32'd1);
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/bia_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// bia_ctrl
// Request sequencer: idle / byte scan / free check, result handoff.
// -----------------------------------------------------------------------------
module bia_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_op,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  bia_pkg::t_sts      i_sts,
    output bia_pkg::t_cmd      o_cmd
);
    import bia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FREE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;
    logic   w_accept;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.alloc  = (r_state == S_SCAN);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == OP_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.open_found || i_sts.last_byte) begin
                    // found a byte, or map is full: finish once the slot frees
                    if (w_slot_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FREE: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- sv/bia_datapath.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// bia_datapath
// Allocation bitmap, live count, scan pointer and result register.
// -----------------------------------------------------------------------------
module bia_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  bia_pkg::t_in_item  i_in,
    input  bia_pkg::t_cmd      i_cmd,
    output bia_pkg::t_sts      o_sts,
    output bia_pkg::t_out_item o_out
);
    import bia_pkg::*;

    logic [7:0] r_map [MAP_BYTES];
    t_cnt       r_count;
    t_idx       r_idx;
    logic [7:0] r_free_id;
    t_out_item  r_out, n_out;

    t_idx       w_free_idx;
    t_idx       w_addr;
    logic [7:0] w_byte;
    logic [7:0] w_open;
    logic [2:0] w_bit;
    logic [2:0] w_free_bit;
    logic       w_in_range;
    logic       w_free_ok;
    t_full_id   w_full_id;

    assign w_free_idx = t_idx'(r_free_id >> 3);
    assign w_free_bit = r_free_id[2:0];
    assign w_addr     = i_cmd.alloc ? r_idx : w_free_idx;
    assign w_byte     = r_map[w_addr];
    assign w_open     = valid_mask(r_idx) & ~w_byte;
    assign w_in_range = (32'(r_free_id) < MAX_IDS);
    assign w_free_ok  = w_in_range && w_byte[w_free_bit];
    assign w_full_id  = {r_idx, w_bit};

    // lowest clear bit
    always_comb begin
        w_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (w_open[i]) begin
                w_bit = 3'(i);
            end
        end
    end

    assign o_sts.open_found = |w_open;
    assign o_sts.last_byte  = (r_idx == t_idx'(MAP_BYTES - 1));

    always_comb begin
        n_out            = r_out;
        n_out.given_id   = '0;
        n_out.live_count = 9'(r_count);
        if (i_cmd.alloc) begin
            if (|w_open) begin
                n_out.status     = ST_OK;
                n_out.given_id   = 8'(w_full_id);
                n_out.live_count = 9'(r_count + t_cnt'(1));
            end else begin
                n_out.status = ST_FULL;
            end
        end else begin
            if (w_free_ok) begin
                n_out.status = ST_OK;
                if (r_count != '0) begin
                    n_out.live_count = 9'(r_count - t_cnt'(1));
                end
            end else begin
                n_out.status = ST_BAD_FREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_BYTES; i++) begin
                r_map[i] <= 8'h00;
            end
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (i_cmd.alloc) begin
                if (|w_open) begin
                    r_map[r_idx][w_bit] <= 1'b1;
                    r_count             <= r_count + t_cnt'(1);
                end
            end else if (w_free_ok) begin
                r_map[w_free_idx][w_free_bit] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - t_cnt'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx     <= '0;
            r_free_id <= i_in.free_id;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + t_idx'(1);
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ----- sv/bitmap_id_allocator.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// bitmap_id_allocator
// First-free ID allocator over a byte-organized bitmap with a live count.
// -----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | request   | i_in_valid / o_in_stall  | op, free_id
//   out     | result    | o_out_valid / i_out_stall| status, given_id, live_count
//
// Allocate: accept, then a byte-by-byte scan of the bitmap from byte 0 to the
//   first non-full byte (or the last byte), then commit once the result slot
//   is free. The single byte-wide scan port over the map forces the byte scan.
// Free: accept, then byte check and update once the result slot is free.
// Reset (synchronous, active low) clears the whole bitmap and count at once.
// A result waits in its own register; a new request is taken while it sits
// stalled, but the next request cannot finish until that register is taken.
// -----------------------------------------------------------------------------
module bitmap_id_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  bia_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bia_pkg::t_out_item o_out
);
    import bia_pkg::*;

    t_cmd w_cmd;  // sequencer commands to the datapath
    t_sts w_sts;  // scan / check status back to the sequencer

    // Sequencer: idle, byte-by-byte scan for allocate, one-shot check for free.
    bia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Bitmap, counter, scan pointer and result register.
    bia_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

    // A result is only written when the output register is free or draining.
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result committed over a held result");

    // After a request is taken the block reports busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted with no busy cycle");

    // Full is reported only when every ID is live.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FULL) |-> (o_out.live_count == 9'(MAX_IDS)))
        else $error("full reported with free IDs left");

    // Scan advance and completion never coincide.
    a_step_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_cmd.commit)
        else $error("scan stepped on completion");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap ID allocator. A scoreboard tracks its own
// copy of the allocation map and live count and predicts each result from the
// accepted request. Stimulus is a short directed opening, then random fill,
// drain and mixed bursts under three idling profiles on both channels.
// -----------------------------------------------------------------------------
import bia_pkg::*;

class id_map_scoreboard;

    bit [MAX_IDS-1:0] id_used;
    int unsigned      live_ids;
    t_out_item        answer_q[$];
    int unsigned      mismatches;

    function new();
        id_used    = '0;
        live_ids   = 0;
        mismatches = 0;
    endfunction

    // Apply one accepted request to the map and queue the answer it must get.
    function void note_request(t_in_item req);
        t_out_item ans;
        int        slot;
        ans.status   = ST_OK;
        ans.given_id = 8'd0;
        if (req.op == OP_ALLOC) begin
            // lowest byte first, then lowest bit == lowest clear ID overall
            slot = -1;
            for (int id = 0; id < MAX_IDS; id++) begin
                if (!id_used[id]) begin
                    slot = id;
                    break;
                end
            end
            if (slot < 0) begin
                ans.status = ST_FULL;
            end else begin
                id_used[slot] = 1'b1;
                live_ids++;
                ans.given_id = 8'(slot);
            end
        end else begin
            if (int'(req.free_id) >= MAX_IDS || !id_used[req.free_id]) begin
                ans.status = ST_BAD_FREE;
            end else begin
                id_used[req.free_id] = 1'b0;
                if (live_ids > 0) live_ids--;
            end
        end
        ans.live_count = 9'(live_ids);
        answer_q.push_back(ans);
    endfunction

    task report(string msg);
        $display("[%0t] error: %s", $time, msg);
        mismatches++;
    endtask

    task check_result(t_out_item got);
        t_out_item want;
        if (answer_q.size() == 0) begin
            report($sformatf("result with nothing outstanding (status %0d id %0d)",
                             got.status, got.given_id));
        end else begin
            want = answer_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.given_id != want.given_id)
                report($sformatf("given_id %0d, want %0d", got.given_id, want.given_id));
            if (got.live_count != want.live_count)
                report($sformatf("live_count %0d, want %0d",
                                 got.live_count, want.live_count));
        end
    endtask

    function int unsigned outstanding();
        return answer_q.size();
    endfunction

    // Random ID that is currently allocated; random ID if the map is empty.
    function logic [7:0] pick_live_id();
        int start;
        int idx;
        start = $urandom_range(MAX_IDS - 1);
        for (int k = 0; k < MAX_IDS; k++) begin
            idx = (start + k) % MAX_IDS;
            if (id_used[idx]) return 8'(idx);
        end
        return 8'($urandom_range(255));
    endfunction

endclass

module tb;

    localparam int PHASE_REQS   = 560;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 40;     // quiet time after the last answer, to catch stray results

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_burst_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    int in_idle_pct  = 18;
    int out_idle_pct = 80;
    int quiet_cycles = 0;

    id_map_scoreboard sb = new();

    bitmap_id_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side backpressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Result monitor and watchdog. Outputs are read right at the edge, before
    // any nonblocking update of this step lands, so they are pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("bitmap_id_allocator: mismatch");
                $finish;
            end
        end
    end

    // Present one request, with a random gap ahead of it, and hold it until
    // taken. The map is updated here at the accepting edge, so the next
    // request is built from an up-to-date picture of what is allocated.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    // free_id is random on allocates too: the block must ignore it there.
    function automatic t_in_item make_request(int alloc_pct, int live_pct);
        t_in_item r;
        r.free_id = 8'($urandom_range(255));
        if ($urandom_range(99) < alloc_pct) begin
            r.op = OP_ALLOC;
        end else begin
            r.op = OP_FREE;
            if ($urandom_range(99) < live_pct) r.free_id = sb.pick_live_id();
        end
        return r;
    endfunction

    initial begin
        int          sent;
        int          burst_len;
        int          alloc_pct;
        int          live_pct;
        int          roll;
        t_burst_mode mode;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed opening ---
        send_request(t_in_item'{OP_FREE,  8'd0});     // free on an empty map
        send_request(t_in_item'{OP_ALLOC, 8'hff});    // first ID, junk free_id
        send_request(t_in_item'{OP_ALLOC, 8'h00});
        send_request(t_in_item'{OP_ALLOC, 8'h55});
        send_request(t_in_item'{OP_FREE,  8'd1});     // punch a hole
        send_request(t_in_item'{OP_FREE,  8'd1});     // double free
        send_request(t_in_item'{OP_ALLOC, 8'haa});    // hole gets reused
        send_request(t_in_item'{OP_FREE,  8'd255});   // top ID, never allocated
        send_request(t_in_item'{OP_FREE,  8'd0});
        send_request(t_in_item'{OP_FREE,  8'd2});
        send_request(t_in_item'{OP_FREE,  8'd1});     // back to empty
        send_request(t_in_item'{OP_FREE,  8'd128});
        // walk across the first byte boundary
        for (int k = 0; k < 9; k++) send_request(make_request(100, 0));
        send_request(t_in_item'{OP_FREE,  8'd7});
        send_request(t_in_item'{OP_ALLOC, 8'h7f});

        // --- random bursts, three idling profiles ---
        // Every profile opens with a fill long enough to run the map full,
        // so the full answer, the top ID and the maximum live count all show
        // up; later bursts wander between filling, draining and churn.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct  = 18;
                    out_idle_pct = 80;
                end
                1: begin
                    in_idle_pct  = 80;
                    out_idle_pct = 18;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_REQS) begin
                if (sent == 0) begin
                    mode      = MODE_FILL;
                    burst_len = MAX_IDS + 64;
                end else begin
                    roll      = $urandom_range(99);
                    mode      = (roll < 30) ? MODE_FILL :
                                (roll < 60) ? MODE_DRAIN : MODE_MIX;
                    burst_len = $urandom_range(200, 10);
                end
                case (mode)
                    MODE_FILL: begin
                        alloc_pct = 92;
                        live_pct  = 50;
                    end
                    MODE_DRAIN: begin
                        alloc_pct = 10;
                        live_pct  = 90;
                    end
                    default: begin
                        alloc_pct = 50;
                        live_pct  = 75;
                    end
                endcase
                repeat (burst_len) begin
                    send_request(make_request(alloc_pct, live_pct));
                    sent++;
                end
            end
        end
        i_in_valid <= 1'b0;

        // let every answer come back, then watch for strays
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("bitmap_id_allocator: match");
        else
            $display("bitmap_id_allocator: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bia_pkg.sv
sv/bia_ctrl.sv
sv/bia_datapath.sv
sv/bitmap_id_allocator.sv
dv/tb.sv
